// ----- design/ria_pkg.sv -----
package ria_pkg;

    // Fixed-point format and tuning constants.
    localparam int FRAC_BITS = 16;
    localparam int EPSILON   = 1;

    localparam int CRD_W   = 32;                    // coordinate width
    localparam int PROD_W  = 2 * CRD_W;             // exact product width
    localparam int VAL_W   = PROD_W - FRAC_BITS + 3; // plane sums and distances
    localparam int T_W     = 31;                    // ray distance width
    localparam int SQ_W    = 48;                    // squared distance width
    localparam int RAD_W   = 48;                    // radius register width
    localparam int HI_W    = VAL_W - CRD_W;         // upper part of a distance
    localparam int SQF_W   = 2 * VAL_W;             // full square width

    localparam int DIV_BPS    = 2;                  // quotient bits per stage
    localparam int DIV_STAGES = 16;
    localparam int Q_BITS     = DIV_BPS * DIV_STAGES;

    localparam logic [T_W-1:0]  T_MAX  = {T_W{1'b1}};
    localparam logic [SQ_W-1:0] SQ_MAX = {SQ_W{1'b1}};
    localparam logic [VAL_W-1:0] EPS_V = VAL_W'(EPSILON);
    localparam logic [T_W-1:0]   EPS_T = T_W'(EPSILON);

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = RAD_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CENTER_X = 3'd0,
        CFG_CENTER_Y = 3'd1,
        CFG_CENTER_Z = 3'd2,
        CFG_NORMAL_A = 3'd3,
        CFG_NORMAL_B = 3'd4,
        CFG_NORMAL_C = 3'd5,
        CFG_OUTER_SQ = 3'd6,
        CFG_INNER_SQ = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        logic signed [CRD_W-1:0] origin_x;
        logic signed [CRD_W-1:0] origin_y;
        logic signed [CRD_W-1:0] origin_z;
        logic signed [CRD_W-1:0] dir_x;
        logic signed [CRD_W-1:0] dir_y;
        logic signed [CRD_W-1:0] dir_z;
    } ray_t;

    typedef struct packed {
        logic           hit;
        logic [T_W-1:0] distance_t;
    } res_t;

    // One entry of the divider pipeline.
    typedef struct packed {
        logic [VAL_W-1:0]  rem;
        logic [Q_BITS-1:0] quo;
        logic [VAL_W-1:0]  num;
        logic [VAL_W-1:0]  den;
        logic              miss;
        logic              sat;
        ray_t              ray;
    } div_t;

    typedef struct packed {
        logic [VAL_W-1:0] rem;
        logic             qbit;
    } step_t;

    // Floor of x / 2^FRAC_BITS.
    function automatic logic signed [PROD_W-1:0] fshift(input logic signed [PROD_W-1:0] x);
        return x >>> FRAC_BITS;
    endfunction

    function automatic logic [VAL_W-1:0] mag(input logic signed [VAL_W-1:0] x);
        logic [VAL_W-1:0] u;
        u = x;
        return x[VAL_W-1] ? (~u + VAL_W'(1)) : u;
    endfunction

    // Bit i of the dividend num * 2^FRAC_BITS.
    function automatic logic num_bit(input logic [VAL_W-1:0] num, input int i);
        logic b;
        b = 1'b0;
        if (i >= FRAC_BITS)
        begin
            b = num[i-FRAC_BITS];
        end
        return b;
    endfunction

    // One restoring division step.
    function automatic step_t div_step(input logic [VAL_W-1:0] rem, input logic nb,
                                       input logic [VAL_W-1:0] den);
        logic [VAL_W:0] r;
        step_t          s;
        r = {rem, nb};
        if (r >= {1'b0, den})
        begin
            r      = r - {1'b0, den};
            s.qbit = 1'b1;
        end
        else
        begin
            s.qbit = 1'b0;
        end
        s.rem = r[VAL_W-1:0];
        return s;
    endfunction

endpackage

// ----- design/ray_annulus_intersect.sv -----
// Ray against flat ring test, one ray per clock while the output is not stalled.
//
// Input channel in_valid / in_stall / in_data carries a ray (origin and
// direction, signed Q16.16). Output channel out_valid / out_stall / out_data
// carries one result transaction per ray: a hit flag and the ray distance t
// (unsigned Q15.16, zero on a miss). Results leave in the order rays came in.
//
// The ring is set up through the write port cfg_wen / cfg_index / cfg_data:
// centre, plane normal and the squared outer and inner radii. The user must write
// registers only while no transaction is in flight; the block does not enforce it.
//
// The pipeline has three stages for the plane dot products, sixteen stages
// of a restoring divider at two quotient bits each, and five stages for the
// hit point and squared distance. Throughput is one transaction per cycle
// while the output is not stalled; the divider pipeline sets depth.
//
// Reset clears all stage valid bits and loads the default ring (centre at the
// origin, normal along z, both radii zero). When the receiver stalls, each
// stage holds only if the stage after it is full, so bubbles are squeezed out
// and in_stall rises only once the whole pipeline is occupied.
module ray_annulus_intersect (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wen,
    input  logic [ria_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [ria_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  ria_pkg::ray_t                       in_data,
    output logic                                out_valid,
    input  logic                                out_stall,
    output ria_pkg::res_t                       out_data
);

    localparam int VW = ria_pkg::VAL_W;
    localparam int PW = ria_pkg::PROD_W;
    localparam int CW = ria_pkg::CRD_W;
    localparam int NS = ria_pkg::DIV_STAGES;

    // Configuration registers.
    logic signed [CW-1:0]           cx_reg, cy_reg, cz_reg;
    logic signed [CW-1:0]           na_reg, nb_reg, nc_reg;
    logic [ria_pkg::RAD_W-1:0]      outer_reg, inner_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cx_reg    <= '0;
            cy_reg    <= '0;
            cz_reg    <= '0;
            na_reg    <= '0;
            nb_reg    <= '0;
            nc_reg    <= CW'(65536);
            outer_reg <= '0;
            inner_reg <= '0;
        end
        else if (cfg_wen)
        begin
            unique case (ria_pkg::cfg_idx_t'(cfg_index))
                ria_pkg::CFG_CENTER_X: cx_reg    <= cfg_data[CW-1:0];
                ria_pkg::CFG_CENTER_Y: cy_reg    <= cfg_data[CW-1:0];
                ria_pkg::CFG_CENTER_Z: cz_reg    <= cfg_data[CW-1:0];
                ria_pkg::CFG_NORMAL_A: na_reg    <= cfg_data[CW-1:0];
                ria_pkg::CFG_NORMAL_B: nb_reg    <= cfg_data[CW-1:0];
                ria_pkg::CFG_NORMAL_C: nc_reg    <= cfg_data[CW-1:0];
                ria_pkg::CFG_OUTER_SQ: outer_reg <= cfg_data;
                ria_pkg::CFG_INNER_SQ: inner_reg <= cfg_data;
                default:               outer_reg <= outer_reg;
            endcase
        end
    end

    // Stage valid bits and the advance chain. A stage may load when it is
    // empty or when the stage after it loads in the same cycle.
    logic          s1_vld_reg, s2_vld_reg, s3_vld_reg;
    logic [NS-1:0] dv_vld_reg;
    logic          m_vld_reg, p_vld_reg, q_vld_reg, c_vld_reg, out_vld_reg;
    logic          adv_s1, adv_s2, adv_s3, adv_m, adv_p, adv_q, adv_c, adv_out;
    logic [NS-1:0] adv_dv;

    assign adv_out = !out_vld_reg || !out_stall;
    assign adv_c   = !c_vld_reg   || adv_out;
    assign adv_q   = !q_vld_reg   || adv_c;
    assign adv_p   = !p_vld_reg   || adv_q;
    assign adv_m   = !m_vld_reg   || adv_p;
    assign adv_s3  = !s3_vld_reg  || adv_dv[0];
    assign adv_s2  = !s2_vld_reg  || adv_s3;
    assign adv_s1  = !s1_vld_reg  || adv_s2;
    assign in_stall = !adv_s1;

    // Stage 1: the nine plane products.
    logic signed [PW-1:0] p1_reg [9];
    ria_pkg::ray_t        r1_reg;

    always_ff @(posedge clk)
    begin
        if (adv_s1)
        begin
            p1_reg[0] <= PW'(na_reg) * PW'(in_data.dir_x);
            p1_reg[1] <= PW'(nb_reg) * PW'(in_data.dir_y);
            p1_reg[2] <= PW'(nc_reg) * PW'(in_data.dir_z);
            p1_reg[3] <= PW'(na_reg) * PW'(in_data.origin_x);
            p1_reg[4] <= PW'(nb_reg) * PW'(in_data.origin_y);
            p1_reg[5] <= PW'(nc_reg) * PW'(in_data.origin_z);
            p1_reg[6] <= PW'(cx_reg) * PW'(na_reg);
            p1_reg[7] <= PW'(cy_reg) * PW'(nb_reg);
            p1_reg[8] <= PW'(cz_reg) * PW'(nc_reg);
            r1_reg    <= in_data;
        end
    end

    // Stage 2: F = N.V and E = N.O + D.
    logic signed [VW-1:0] f2_reg, e2_reg;
    ria_pkg::ray_t        r2_reg;
    logic signed [PW-1:0] f_sum, e_sum;

    always_comb
    begin
        f_sum = ria_pkg::fshift(p1_reg[0]) + ria_pkg::fshift(p1_reg[1])
              + ria_pkg::fshift(p1_reg[2]);
        e_sum = ria_pkg::fshift(p1_reg[3]) + ria_pkg::fshift(p1_reg[4])
              + ria_pkg::fshift(p1_reg[5])
              - (ria_pkg::fshift(p1_reg[6]) + ria_pkg::fshift(p1_reg[7])
              + ria_pkg::fshift(p1_reg[8]));
    end

    always_ff @(posedge clk)
    begin
        if (adv_s2)
        begin
            f2_reg <= f_sum[VW-1:0];
            e2_reg <= e_sum[VW-1:0];
            r2_reg <= r1_reg;
        end
    end

    // Stage 3: magnitudes, miss and saturation tests, divider seed.
    ria_pkg::div_t s3_reg;
    ria_pkg::div_t s3_next;
    logic [VW-1:0] n3, d3;

    always_comb
    begin
        n3 = ria_pkg::mag(e2_reg);
        d3 = ria_pkg::mag(f2_reg);
        s3_next.num  = n3;
        s3_next.den  = d3;
        s3_next.rem  = n3 >> (ria_pkg::Q_BITS - ria_pkg::FRAC_BITS);
        s3_next.quo  = '0;
        s3_next.sat  = (n3 >> (ria_pkg::Q_BITS - 1 - ria_pkg::FRAC_BITS)) >= d3;
        s3_next.miss = (d3 < ria_pkg::EPS_V) || (e2_reg == '0)
                    || (e2_reg[VW-1] == f2_reg[VW-1]);
        s3_next.ray  = r2_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv_s3)
        begin
            s3_reg <= s3_next;
        end
    end

    // Divider pipeline, DIV_BPS quotient bits per stage.
    ria_pkg::div_t dv_reg [NS];

    for (genvar j = 0; j < NS; j++)
    begin : g_div
        ria_pkg::div_t dv_in;
        ria_pkg::div_t dv_next;

        if (j == 0)
        begin : g_first
            assign dv_in = s3_reg;
        end
        else
        begin : g_rest
            assign dv_in = dv_reg[j-1];
        end

        if (j == NS - 1)
        begin : g_last
            assign adv_dv[j] = !dv_vld_reg[j] || adv_m;
        end
        else
        begin : g_mid
            assign adv_dv[j] = !dv_vld_reg[j] || adv_dv[j+1];
        end

        always_comb
        begin
            ria_pkg::step_t st;
            dv_next = dv_in;
            for (int k = 0; k < ria_pkg::DIV_BPS; k++)
            begin
                st = ria_pkg::div_step(dv_next.rem,
                        ria_pkg::num_bit(dv_in.num,
                            ria_pkg::Q_BITS - 1 - j * ria_pkg::DIV_BPS - k),
                        dv_in.den);
                dv_next.rem = st.rem;
                dv_next.quo = {dv_next.quo[ria_pkg::Q_BITS-2:0], st.qbit};
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv_dv[j])
            begin
                dv_reg[j] <= dv_next;
            end
        end
    end

    // Stage M: final t and the products t * V.
    logic [ria_pkg::T_W-1:0] tq;
    logic                    m_miss;
    logic signed [PW-1:0]    pm_reg [3];
    logic [ria_pkg::T_W-1:0] tm_reg;
    logic                    mm_reg;
    ria_pkg::ray_t           rm_reg;
    logic signed [CW-1:0]    tq_s;

    always_comb
    begin
        tq     = dv_reg[NS-1].sat ? ria_pkg::T_MAX : dv_reg[NS-1].quo[ria_pkg::T_W-1:0];
        m_miss = dv_reg[NS-1].miss || (tq < ria_pkg::EPS_T);
        tq_s   = {1'b0, tq};
    end

    always_ff @(posedge clk)
    begin
        if (adv_m)
        begin
            pm_reg[0] <= PW'(tq_s) * PW'(dv_reg[NS-1].ray.dir_x);
            pm_reg[1] <= PW'(tq_s) * PW'(dv_reg[NS-1].ray.dir_y);
            pm_reg[2] <= PW'(tq_s) * PW'(dv_reg[NS-1].ray.dir_z);
            tm_reg    <= tq;
            mm_reg    <= m_miss;
            rm_reg    <= dv_reg[NS-1].ray;
        end
    end

    // Stage P: hit point and distance to the centre, split in two halves.
    logic signed [PW-1:0]         px [3];
    logic signed [PW-1:0]         dfull [3];
    logic [VW-1:0]                dmag [3];
    logic [ria_pkg::HI_W-1:0]     hi_reg [3];
    logic [CW-1:0]                lo_reg [3];
    logic [ria_pkg::T_W-1:0]      tp_reg;
    logic                         mp_reg;

    always_comb
    begin
        px[0]    = PW'(rm_reg.origin_x) + ria_pkg::fshift(pm_reg[0]);
        px[1]    = PW'(rm_reg.origin_y) + ria_pkg::fshift(pm_reg[1]);
        px[2]    = PW'(rm_reg.origin_z) + ria_pkg::fshift(pm_reg[2]);
        dfull[0] = PW'(cx_reg) - px[0];
        dfull[1] = PW'(cy_reg) - px[1];
        dfull[2] = PW'(cz_reg) - px[2];
        for (int k = 0; k < 3; k++)
        begin
            dmag[k] = ria_pkg::mag(dfull[k][VW-1:0]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv_p)
        begin
            for (int k = 0; k < 3; k++)
            begin
                hi_reg[k] <= dmag[k][VW-1:CW];
                lo_reg[k] <= dmag[k][CW-1:0];
            end
            tp_reg <= tm_reg;
            mp_reg <= mm_reg;
        end
    end

    // Stage Q: partial products of each square.
    logic [2*ria_pkg::HI_W-1:0]      hh_reg [3];
    logic [ria_pkg::HI_W+CW-1:0]     hl_reg [3];
    logic [2*CW-1:0]                 ll_reg [3];
    logic [ria_pkg::T_W-1:0]         tsq_reg;
    logic                            msq_reg;

    always_ff @(posedge clk)
    begin
        if (adv_q)
        begin
            for (int k = 0; k < 3; k++)
            begin
                hh_reg[k] <= (2*ria_pkg::HI_W)'(hi_reg[k]) * (2*ria_pkg::HI_W)'(hi_reg[k]);
                hl_reg[k] <= (ria_pkg::HI_W+CW)'(hi_reg[k]) * (ria_pkg::HI_W+CW)'(lo_reg[k]);
                ll_reg[k] <= (2*CW)'(lo_reg[k]) * (2*CW)'(lo_reg[k]);
            end
            tsq_reg <= tp_reg;
            msq_reg <= mp_reg;
        end
    end

    // Stage C: assemble each square, scale and saturate.
    logic [ria_pkg::SQF_W-1:0] sq_full [3];
    logic [ria_pkg::SQF_W-1:0] sq_sh [3];
    logic [ria_pkg::SQ_W-1:0]  comp_reg [3];
    logic [ria_pkg::T_W-1:0]   tc_reg;
    logic                      mc_reg;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            sq_full[k] = (ria_pkg::SQF_W'(hh_reg[k]) << (2*CW))
                       + (ria_pkg::SQF_W'(hl_reg[k]) << (CW+1))
                       + ria_pkg::SQF_W'(ll_reg[k]);
            sq_sh[k]   = sq_full[k] >> ria_pkg::FRAC_BITS;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv_c)
        begin
            for (int k = 0; k < 3; k++)
            begin
                comp_reg[k] <= (sq_sh[k] > ria_pkg::SQF_W'(ria_pkg::SQ_MAX))
                             ? ria_pkg::SQ_MAX : sq_sh[k][ria_pkg::SQ_W-1:0];
            end
            tc_reg <= tsq_reg;
            mc_reg <= msq_reg;
        end
    end

    // Output stage: sum, ring test, result register.
    logic [ria_pkg::SQ_W+1:0] dsum;
    logic [ria_pkg::SQ_W-1:0] dist_sat;
    ria_pkg::res_t            res_next;
    ria_pkg::res_t            out_reg;

    always_comb
    begin
        dsum = (ria_pkg::SQ_W+2)'(comp_reg[0]) + (ria_pkg::SQ_W+2)'(comp_reg[1])
             + (ria_pkg::SQ_W+2)'(comp_reg[2]);
        dist_sat = (dsum > (ria_pkg::SQ_W+2)'(ria_pkg::SQ_MAX))
                 ? ria_pkg::SQ_MAX : dsum[ria_pkg::SQ_W-1:0];
        res_next.hit        = !mc_reg && (outer_reg > dist_sat) && (inner_reg < dist_sat);
        res_next.distance_t = res_next.hit ? tc_reg : '0;
    end

    always_ff @(posedge clk)
    begin
        if (adv_out)
        begin
            out_reg <= res_next;
        end
    end

    // Valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg  <= 1'b0;
            s2_vld_reg  <= 1'b0;
            s3_vld_reg  <= 1'b0;
            dv_vld_reg  <= '0;
            m_vld_reg   <= 1'b0;
            p_vld_reg   <= 1'b0;
            q_vld_reg   <= 1'b0;
            c_vld_reg   <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (adv_s1)
            begin
                s1_vld_reg <= in_valid;
            end
            if (adv_s2)
            begin
                s2_vld_reg <= s1_vld_reg;
            end
            if (adv_s3)
            begin
                s3_vld_reg <= s2_vld_reg;
            end
            for (int j = 0; j < NS; j++)
            begin
                if (adv_dv[j])
                begin
                    dv_vld_reg[j] <= (j == 0) ? s3_vld_reg : dv_vld_reg[(j == 0) ? 0 : j-1];
                end
            end
            if (adv_m)
            begin
                m_vld_reg <= dv_vld_reg[NS-1];
            end
            if (adv_p)
            begin
                p_vld_reg <= m_vld_reg;
            end
            if (adv_q)
            begin
                q_vld_reg <= p_vld_reg;
            end
            if (adv_c)
            begin
                c_vld_reg <= q_vld_reg;
            end
            if (adv_out)
            begin
                out_vld_reg <= c_vld_reg;
            end
        end
    end

    assign out_valid = out_vld_reg;
    assign out_data  = out_reg;

    // A miss always reports a zero distance.
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && !out_reg.hit) |-> (out_reg.distance_t == '0))
        else $error("miss result carries a nonzero distance");

    // A hit never reports a distance below the near limit.
    a_hit_far: assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && out_reg.hit) |-> (out_reg.distance_t >= ria_pkg::EPS_T))
        else $error("hit result closer than the near limit");

    // Nothing is presented in the cycle after reset is released.
    a_reset_empty: assert property (@(posedge clk)
        $rose(rst_n) |-> !out_vld_reg)
        else $error("output valid right after reset");

    // The input is stalled only when every stage holds a transaction.
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_vld_reg && s2_vld_reg && s3_vld_reg && (&dv_vld_reg)
                      && m_vld_reg && p_vld_reg && q_vld_reg && c_vld_reg
                      && out_vld_reg))
        else $error("input stalled while a pipeline stage is empty");

endmodule
